/* hw/rtl/bra_pkg.sv */
// Shared types and constants for the bitmap run allocator.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

    // Store size and register reset value
    localparam int          MAP_BYTES_DEF = 128;
    localparam logic [7:0]  CFG_RESET     = 8'd128;

    // Operation codes
    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_SCAN  = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } bra_op_t;

    // Input item
    typedef struct packed {
        bra_op_t     op;
        logic [9:0]  bit_index;
        logic        set_value;
        logic [10:0] run_length;
    } bra_in_t;

    // Result item
    typedef struct packed {
        logic        bit_is_set;
        logic        found;
        logic [9:0]  run_start;
    } bra_out_t;

    // Run unit control from the sequencer
    typedef struct packed {
        logic clear;
        logic step;
    } bra_run_ctl_t;

    // Run unit answer for the byte on hand
    typedef struct packed {
        logic       hit;
        logic [9:0] start;
    } bra_run_res_t;

endpackage

`default_nettype wire

/* hw/rtl/bra_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/bra_run_unit.sv */
// Free-run counter: walks the eight bits of one map byte per step.
`timescale 1ns / 1ps
`default_nettype none

module bra_run_unit #(
    parameter int AW = 7
) (
    input  wire logic                  aclk,
    input  wire bra_pkg::bra_run_ctl_t ctl,
    input  wire logic [7:0]            map_byte,
    input  wire logic [AW-1:0]         byte_addr,
    input  wire logic [10:0]           run_length,
    output bra_pkg::bra_run_res_t      res
);

    import bra_pkg::*;

    // Wide enough for a bit position and for the run length
    localparam int SW = ((AW + 3 > 11) ? AW + 3 : 11) + 1;

    logic [10:0]   run_reg;
    logic [10:0]   run_next;
    logic [10:0]   run_w;
    logic          hit_w;
    logic [SW-1:0] start_w;

    // Count zero bits, least significant first, and stop at the first full run
    always_comb begin
        run_w   = run_reg;
        hit_w   = 1'b0;
        start_w = '0;
        for (int b = 0; b < 8; b++) begin
            if (!hit_w) begin
                if (map_byte[b]) begin
                    run_w = '0;
                end else begin
                    run_w = run_w + 11'd1;
                end
                if (run_w == run_length) begin
                    hit_w   = 1'b1;
                    start_w = SW'({byte_addr, 3'(b)}) + SW'(1) - SW'(run_length);
                end
            end
        end
    end

    // Hold the count across bytes; restart for a new scan
    always_comb begin
        run_next = run_reg;
        if (ctl.clear) begin
            run_next = '0;
        end else if (ctl.step) begin
            run_next = run_w;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg <= run_next;
    end

    assign res.hit   = hit_w;
    assign res.start = start_w[9:0];

endmodule

`default_nettype wire

/* hw/rtl/bitmap_run_allocator_top.sv */
// Top level of the bitmap run allocator: sequencer, map store and run unit.
//
//  channel | ports                          | carries
//  --------+--------------------------------+----------------------------------
//  input   | s_valid, s_ready, s_data       | op, bit_index, set_value, run_length
//  result  | m_valid, m_ready, m_data       | bit_is_set, found, run_start
//  config  | cfg_valid, cfg_ready, cfg_wdata| bytes_in_use
//
// A test or set steps through read, modify/write and respond states.
// A scan walks the map bytes from byte 0 until the run is found or the last byte in use
// (capped at MAP_BYTES) is done; the run unit takes one map byte per cycle.
// Index outside the bits in use, zero run length or no bytes in use: straight to respond.
// A clear-all sweeps the store at one byte per cycle, then responds.
// After reset the same sweep runs with s_ready low.
// One item is in work at a time; the next is taken while a result waits on m_data.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_run_allocator_top #(
    parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bra_pkg::bra_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bra_pkg::bra_out_t     m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_wdata
);

    import bra_pkg::*;

    localparam int AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int IW   = AW + 7;
    localparam int CW   = $clog2(MAP_BYTES + 256) + 1;
    localparam int LAST = MAP_BYTES - 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW_RD,
        ST_RMW,
        ST_SCAN_RD,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    cfg_reg, cfg_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          clr_op_reg, clr_op_next;
    bra_in_t       req_reg, req_next;
    bra_out_t      res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    bra_out_t      m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic [CW-1:0] cfg_w;
    logic [CW-1:0] eff_bytes;
    logic [IW-1:0] idx_byte_w;
    logic          idx_in_range;
    logic          bit_w;
    logic [7:0]    set_byte;
    logic          scan_last;

    bra_run_ctl_t  run_ctl;
    bra_run_res_t  run_res;

    // Managed bytes, capped at the store size
    assign cfg_w     = CW'(cfg_reg);
    assign eff_bytes = (cfg_w > CW'(MAP_BYTES)) ? CW'(MAP_BYTES) : cfg_w;

    // Byte of the addressed bit and its range check
    assign idx_byte_w   = IW'(s_data.bit_index[9:3]);
    assign idx_in_range = CW'(s_data.bit_index[9:3]) < eff_bytes;

    // Read-modify-write data
    assign bit_w    = ram_rdata[req_reg.bit_index[2:0]];
    always_comb begin
        set_byte = ram_rdata;
        set_byte[req_reg.bit_index[2:0]] = req_reg.set_value;
    end

    assign scan_last = CW'(addr_reg) == (eff_bytes - CW'(1));

    // Store port control
    assign ram_we    = (state_reg == ST_CLEAR) ||
                       ((state_reg == ST_RMW) && (req_reg.op == OP_SET));
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'h00 : set_byte;
    assign ram_raddr = (state_reg == ST_SCAN) ? addr_reg + AW'(1) : addr_reg;

    assign run_ctl.clear = (state_reg == ST_SCAN_RD);
    assign run_ctl.step  = (state_reg == ST_SCAN);

    bra_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bra_run_unit #(
        .AW (AW)
    ) u_run (
        .aclk       (aclk),
        .ctl        (run_ctl),
        .map_byte   (ram_rdata),
        .byte_addr  (addr_reg),
        .run_length (req_reg.run_length),
        .res        (run_res)
    );

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        cfg_next     = cfg_reg;
        addr_next    = addr_reg;
        clr_op_next  = clr_op_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_valid) begin
            cfg_next = cfg_wdata;
        end

        // Drop the result once transferred
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == AW'(LAST)) begin
                    addr_next  = '0;
                    state_next = clr_op_reg ? ST_RESP : ST_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    res_next = '0;
                    case (s_data.op)
                        OP_TEST, OP_SET: begin
                            addr_next  = idx_byte_w[AW-1:0];
                            state_next = idx_in_range ? ST_RMW_RD : ST_RESP;
                        end
                        OP_SCAN: begin
                            addr_next = '0;
                            if ((s_data.run_length == 11'd0) || (eff_bytes == CW'(0))) begin
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        OP_CLEAR: begin
                            addr_next   = '0;
                            clr_op_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RMW_RD: begin
                state_next = ST_RMW;
            end
            ST_RMW: begin
                if (req_reg.op == OP_TEST) begin
                    res_next.bit_is_set = bit_w;
                end
                state_next = ST_RESP;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (run_res.hit) begin
                    res_next.found     = 1'b1;
                    res_next.run_start = run_res.start;
                    state_next         = ST_RESP;
                end else if (scan_last) begin
                    state_next = ST_RESP;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    clr_op_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cfg_reg     <= CFG_RESET;
            addr_reg    <= '0;
            clr_op_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            addr_reg    <= addr_next;
            clr_op_reg  <= clr_op_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

`default_nettype wire

/* bench/tb_bitmap_run_allocator_top.sv */
// Self-checking testbench for the bitmap run allocator top level.
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_top;

    import bra_pkg::*;

    localparam int MAP_BITS      = MAP_BYTES_DEF * 8;
    localparam int IN_W          = $bits(bra_in_t);
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = MAP_BYTES_DEF + 16;
    localparam int STALL_LIMIT   = 3000;

    // Traffic shapes for the two channels
    typedef enum int {
        PACE_FULL,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    // Predicts allocator answers and compares them with what comes out
    class alloc_scoreboard;
        bit [MAP_BITS-1:0] map_bits;
        int unsigned       bytes_cfg;
        bra_out_t          answers_q[$];
        int unsigned       fail_count;

        function new();
            map_bits   = '0;
            bytes_cfg  = CFG_RESET;
            fail_count = 0;
        endfunction

        function void write_config(logic [7:0] value);
            bytes_cfg = value;
        endfunction

        // Apply one operation to the map copy and return its answer
        function bra_out_t apply_op(bra_in_t item);
            bra_out_t    res;
            int unsigned limit;
            int unsigned run;
            int unsigned k;
            bit          hit;
            res   = '0;
            limit = ((bytes_cfg > MAP_BYTES_DEF) ? MAP_BYTES_DEF : bytes_cfg) * 8;
            run   = 0;
            hit   = 1'b0;
            case (item.op)
                OP_TEST: begin
                    if (item.bit_index < limit)
                        res.bit_is_set = map_bits[item.bit_index];
                end
                OP_SCAN: begin
                    // first fit: lowest start of a long enough zero run
                    if (item.run_length != 0) begin
                        for (k = 0; k < limit && !hit; k++) begin
                            if (map_bits[k])
                                run = 0;
                            else
                                run++;
                            if (run == item.run_length) begin
                                hit           = 1'b1;
                                res.found     = 1'b1;
                                res.run_start = 10'(k + 1 - item.run_length);
                            end
                        end
                    end
                end
                OP_SET: begin
                    if (item.bit_index < limit)
                        map_bits[item.bit_index] = item.set_value;
                end
                default: begin
                    map_bits = '0;
                end
            endcase
            return res;
        endfunction

        function void note_input(bra_in_t item);
            answers_q.push_back(apply_op(item));
        endfunction

        function void check_result(bra_out_t got);
            bra_out_t want;
            if (answers_q.size() == 0) begin
                $error("unexpected result: bit_is_set %0d found %0d run_start %0d",
                       got.bit_is_set, got.found, got.run_start);
                fail_count++;
                return;
            end
            want = answers_q.pop_front();
            if (got.bit_is_set !== want.bit_is_set) begin
                $error("bit_is_set: expected %0d, actual %0d", want.bit_is_set, got.bit_is_set);
                fail_count++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                fail_count++;
            end
            if (got.run_start !== want.run_start) begin
                $error("run_start: expected %0d, actual %0d", want.run_start, got.run_start);
                fail_count++;
            end
        endfunction

        function int pending();
            return answers_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bra_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    bra_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_wdata;

    alloc_scoreboard sb;
    int unsigned     cur_bits;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int unsigned     hold_req;
    int unsigned     hold_seen;
    int unsigned     hold_left;
    int unsigned     quiet_cycles;

    bitmap_run_allocator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Observe transfers: results first, then new items, then register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (cfg_valid && cfg_ready)
                sb.write_config(cfg_wdata);
        end
    end

    // End the run when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic bra_in_t mk_item(bra_op_t op, int idx, bit value, int len);
        bra_in_t item;
        item.op         = op;
        item.bit_index  = 10'(idx);
        item.set_value  = value;
        item.run_length = 11'(len);
        return item;
    endfunction

    // Random item, biased toward the bits in use and toward short runs
    function automatic bra_in_t random_item();
        bra_in_t     item;
        int unsigned pick;
        int unsigned short_max;
        int          near;
        item = IN_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 38)
            item.op = OP_SET;
        else if (pick < 68)
            item.op = OP_SCAN;
        else if (pick < 97)
            item.op = OP_TEST;
        else
            item.op = OP_CLEAR;
        if (cur_bits != 0 && $urandom_range(99) < 82)
            item.bit_index = 10'($urandom_range(cur_bits - 1));
        item.set_value = ($urandom_range(99) < 65);
        short_max = (cur_bits == 0) ? 8 : ((cur_bits > 48) ? 48 : cur_bits);
        pick = $urandom_range(99);
        if (pick < 6) begin
            item.run_length = 11'($urandom_range(2047));
        end else if (pick < 14) begin
            near = int'(cur_bits) + int'($urandom_range(4)) - 2;
            item.run_length = 11'((near < 0) ? 0 : near);
        end else if (pick < 18) begin
            item.run_length = '0;
        end else begin
            item.run_length = 11'($urandom_range(short_max, 1));
        end
        return item;
    endfunction

    // Offer one item, hold it until transfer, then maybe idle
    task automatic send_item(input bra_in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every predicted answer has come back
    task automatic wait_all_answered();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (sb.pending() != 0);
        @(posedge aclk);
    endtask

    task automatic write_bytes_in_use(input logic [7:0] value);
        wait_all_answered();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_bits = ((value > MAP_BYTES_DEF) ? MAP_BYTES_DEF : value) * 8;
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
            PACE_SENDER_GAPS: begin
                send_idle_pct  = 47;
                recv_stall_pct <= 0;
            end
            PACE_RECEIVER_STALLS: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 47;
            end
            default: begin
                send_idle_pct  = 36;
                recv_stall_pct <= 36;
            end
        endcase
    endtask

    // Random traffic with occasional runs of sets over a contiguous range
    task automatic run_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned base;
        int unsigned len;
        int unsigned j;
        bit          value;
        bra_in_t     item;
        sent = 0;
        while (sent < n_items) begin
            if (cur_bits != 0 && $urandom_range(99) < 8) begin
                base  = $urandom_range(cur_bits - 1);
                len   = $urandom_range(24, 2);
                value = ($urandom_range(99) < 70);
                for (j = 0; j < len; j++) begin
                    item            = IN_W'($urandom);
                    item.op         = OP_SET;
                    item.bit_index  = 10'(base + j);
                    item.set_value  = value;
                    send_item(item);
                    sent++;
                end
            end else begin
                send_item(random_item());
                sent++;
            end
        end
    endtask

    initial begin
        sb             = new();
        cur_bits       = MAP_BITS;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        quiet_cycles   = 0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_data         <= '0;
        cfg_valid      <= 1'b0;
        cfg_wdata      <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty map, field extremes, edges of the store
        send_item(mk_item(OP_TEST, 0, 1'b0, 0));
        send_item(mk_item(OP_TEST, 1023, 1'b1, 2047));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 0));
        send_item(mk_item(OP_SCAN, 1023, 1'b1, 1024));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 1025));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 2047));
        send_item(mk_item(OP_SET, 0, 1'b1, 0));
        send_item(mk_item(OP_SET, 1023, 1'b1, 2047));
        send_item(mk_item(OP_SET, 511, 1'b1, 0));
        send_item(mk_item(OP_TEST, 0, 1'b0, 0));
        send_item(mk_item(OP_TEST, 1023, 1'b0, 0));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 1));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 512));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 511));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 510));
        send_item(mk_item(OP_SET, 0, 1'b0, 0));
        send_item(mk_item(OP_TEST, 0, 1'b0, 0));
        send_item(mk_item(OP_SET, 1023, 1'b0, 0));
        send_item(mk_item(OP_CLEAR, 1023, 1'b1, 2047));
        send_item(mk_item(OP_TEST, 511, 1'b0, 0));
        send_item(mk_item(OP_SCAN, 0, 1'b0, 1024));

        // Full store, back-to-back traffic
        write_bytes_in_use(8'd128);
        set_pace(PACE_FULL);
        run_phase(95);

        // Register above the store size acts as the full store
        write_bytes_in_use(8'd255);
        set_pace(PACE_SENDER_GAPS);
        run_phase(95);

        // Nothing in use: tests read zero, sets drop, scans miss
        write_bytes_in_use(8'd0);
        set_pace(PACE_RECEIVER_STALLS);
        run_phase(60);

        // One byte in use: most indexes fall outside
        write_bytes_in_use(8'd1);
        set_pace(PACE_BOTH);
        run_phase(95);

        // Partial store; hold results off long enough to stall the input
        write_bytes_in_use(8'($urandom_range(127, 2)));
        set_pace(PACE_FULL);
        run_phase(10);
        hold_req <= hold_req + 1;
        run_phase(90);

        // Full store again, exposing bits left beyond the old limit
        write_bytes_in_use(8'd128);
        set_pace(PACE_BOTH);
        run_phase(95);

        // Any nonzero register value; pause the sender midway until drained
        write_bytes_in_use(8'($urandom_range(255, 1)));
        set_pace(PACE_SENDER_GAPS);
        run_phase(45);
        wait_all_answered();
        run_phase(50);

        write_bytes_in_use(8'd128);
        set_pace(PACE_RECEIVER_STALLS);
        run_phase(95);

        // Drain and watch for stray results
        wait_all_answered();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
